[rtl/core/ueq_pkg.sv]
package ueq_pkg;

  // field widths of one request and one result
  localparam int OPCODE_W  = 2;
  localparam int EVENT_W   = 4;
  localparam int HANDLER_W = 8;

  localparam int IN_FIELDS_W  = OPCODE_W + EVENT_W + HANDLER_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 + HANDLER_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic [OPCODE_W-1:0] opcode_t;

  // request opcodes
  localparam opcode_t OP_PUT    = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;
  localparam opcode_t OP_POP    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic latch_in;   // capture the accepted request
    logic chk;        // evaluate the request and hold the result flags
    logic put_entry;  // write handler and links of the new tail entry
    logic put_tail;   // link the new entry behind the old tail
    logic rd_entry;   // read the links of the entry to unlink
    logic sel_head;   // entry to read is the head rather than the event
    logic unlink;     // rewrite the neighbours of the read entry
    logic load_out;   // move the result into the output register
  } ueq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    fail;
    logic    out_free;
  } ueq_stat_t;

endpackage

[rtl/core/ueq_ctrl.sv]
module ueq_ctrl
  import ueq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ueq_stat_t stat,
  output ueq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_PUT_TAIL = 3'd2;
  localparam logic [2:0] S_UNLINK   = 3'd3;
  localparam logic [2:0] S_RESP     = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.chk = 1'b1;
        if (stat.fail) begin
          state_nxt = S_RESP;
        end else begin
          case (stat.op)
            OP_PUT: begin
              cmd.put_entry = 1'b1;
              state_nxt     = S_PUT_TAIL;
            end
            OP_REMOVE, OP_POP: begin
              cmd.rd_entry = 1'b1;
              cmd.sel_head = (stat.op == OP_POP);
              state_nxt    = S_UNLINK;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_PUT_TAIL: begin
        cmd.put_tail = 1'b1;
        state_nxt    = S_RESP;
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ueq_dpath.sv]
module ueq_dpath
  import ueq_pkg::*;
#(
  parameter int NUM_EVENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  ueq_cmd_t               cmd,
  output ueq_stat_t              stat
);

  localparam int IDX_W  = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int LINK_W = $clog2(NUM_EVENTS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_EVENTS);

  // captured request
  opcode_t              op_r;
  logic [EVENT_W-1:0]   ev_r;
  logic [HANDLER_W-1:0] hd_r;

  // list state
  logic [NUM_EVENTS-1:0] flags_r;
  logic [LINK_W-1:0]     head_r;
  logic [LINK_W-1:0]     tail_r;
  logic [LINK_W-1:0]     cur_r;

  // link and handler memories
  logic [LINK_W-1:0]    next_mem [NUM_EVENTS];
  logic [LINK_W-1:0]    prev_mem [NUM_EVENTS];
  logic [HANDLER_W-1:0] hand_mem [NUM_EVENTS];

  // registered read data
  logic [LINK_W-1:0]    rd_next_r;
  logic [LINK_W-1:0]    rd_prev_r;
  logic [HANDLER_W-1:0] rd_hand_r;

  // result flags and output register
  logic                 res_status_r;
  logic                 res_isq_r;
  logic                 res_pv_r;
  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [31:0]       ev_ext;
  logic              ev_ok;
  logic [IDX_W-1:0]  ev_idx;
  logic [LINK_W-1:0] ev_link;
  logic              ev_queued;
  logic              head_ok;
  logic              tail_ok;
  logic              prev_ok;
  logic              next_ok;
  logic              fail;
  logic              out_free;
  logic [LINK_W-1:0] rd_slot;

  logic              nx_we;
  logic [IDX_W-1:0]  nx_addr;
  logic [LINK_W-1:0] nx_data;
  logic              pv_we;
  logic [IDX_W-1:0]  pv_addr;
  logic [LINK_W-1:0] pv_data;

  // event decode
  assign ev_ext    = 32'(ev_r);
  assign ev_ok     = (ev_ext < 32'(NUM_EVENTS));
  assign ev_idx    = ev_ext[IDX_W-1:0];
  assign ev_link   = ev_ext[LINK_W-1:0];
  assign ev_queued = ev_ok & flags_r[ev_idx];
  assign head_ok   = (head_r != NULL_LINK);
  assign tail_ok   = (tail_r != NULL_LINK);
  assign prev_ok   = (rd_prev_r != NULL_LINK);
  assign next_ok   = (rd_next_r != NULL_LINK);
  assign rd_slot   = cmd.sel_head ? head_r : ev_link;

  // invalid state check per opcode
  always_comb begin
    case (op_r)
      OP_PUT:    fail = !ev_ok || ev_queued;
      OP_REMOVE: fail = !ev_queued;
      OP_POP:    fail = !head_ok;
      default:   fail = 1'b0;
    endcase
  end

  assign out_free      = !out_valid_r || out_tready;
  assign stat.op       = op_r;
  assign stat.fail     = fail;
  assign stat.out_free = out_free;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= in_tdata[OPCODE_W-1:0];
      ev_r <= in_tdata[OPCODE_W+EVENT_W-1:OPCODE_W];
      hd_r <= in_tdata[IN_FIELDS_W-1:OPCODE_W+EVENT_W];
    end
  end

  // next link write port
  always_comb begin
    nx_we   = 1'b0;
    nx_addr = ev_idx;
    nx_data = NULL_LINK;
    if (cmd.put_entry) begin
      nx_we = 1'b1;
    end else if (cmd.put_tail) begin
      nx_we   = tail_ok;
      nx_addr = tail_r[IDX_W-1:0];
      nx_data = ev_link;
    end else if (cmd.unlink) begin
      nx_we   = prev_ok;
      nx_addr = rd_prev_r[IDX_W-1:0];
      nx_data = rd_next_r;
    end
  end

  // prev link write port
  always_comb begin
    pv_we   = 1'b0;
    pv_addr = ev_idx;
    pv_data = tail_r;
    if (cmd.put_entry) begin
      pv_we = 1'b1;
    end else if (cmd.unlink) begin
      pv_we   = next_ok;
      pv_addr = rd_next_r[IDX_W-1:0];
      pv_data = rd_prev_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    if (cmd.put_entry) begin
      hand_mem[ev_idx] <= hd_r;
    end
    if (cmd.rd_entry) begin
      rd_next_r <= next_mem[rd_slot[IDX_W-1:0]];
      rd_prev_r <= prev_mem[rd_slot[IDX_W-1:0]];
      rd_hand_r <= hand_mem[rd_slot[IDX_W-1:0]];
      cur_r     <= rd_slot;
    end
  end

  // head, tail and queued flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      head_r  <= NULL_LINK;
      tail_r  <= NULL_LINK;
    end else if (cmd.put_tail) begin
      flags_r[ev_idx] <= 1'b1;
      tail_r          <= ev_link;
      if (!tail_ok) begin
        head_r <= ev_link;
      end
    end else if (cmd.unlink) begin
      flags_r[cur_r[IDX_W-1:0]] <= 1'b0;
      if (!prev_ok) begin
        head_r <= rd_next_r;
      end
      if (!next_ok) begin
        tail_r <= rd_prev_r;
      end
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      res_status_r <= fail;
      res_isq_r    <= (op_r == OP_QUERY) && ev_queued;
      res_pv_r     <= (op_r == OP_POP) && head_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= OUT_TDATA_W'({(res_pv_r ? rd_hand_r : {HANDLER_W{1'b0}}),
                                  res_pv_r, res_isq_r, res_status_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // an empty list has both ends null
  a_ends_null: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NULL_LINK) == (tail_r == NULL_LINK))
    else $error("head and tail disagree on an empty list");

  // no queued flag is set while the list is empty
  a_flags_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(flags_r) == 0) == (head_r == NULL_LINK))
    else $error("queued flags disagree with the head pointer");

  // the head entry is always marked queued
  a_head_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != NULL_LINK) |-> flags_r[head_r[IDX_W-1:0]])
    else $error("head entry is not marked queued");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over a waiting result");
`endif

endmodule

[rtl/core/unique_event_queue.sv]
// ordered queue of up to NUM_EVENTS distinct event slots, each carrying a
// handler number; put appends at the tail, remove unlinks from any position,
// query reports membership and pop returns the head's handler, each request
// giving exactly one result. one request is handled at a time: a put, remove
// or pop that succeeds goes from check via put-tail or unlink to response, a
// query or a request that reports invalid state from check straight to
// response; the steps are set by the single write port and registered read
// of the link memories (a remove reads the entry's links, then rewrites both
// neighbours). the result register lets the next request be taken while a
// result waits. the link and handler memories need no clearing after reset,
// so requests are accepted from the first cycle out of reset.
module unique_event_queue
  import ueq_pkg::*;
#(
  parameter int NUM_EVENTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode[1:0], event_id[5:2], handler_id[13:6], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[0], is_queued[1], popped_valid[2], popped_handler[10:3], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ueq_cmd_t  cmd;
  ueq_stat_t stat;

  // sequencer
  ueq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // list storage and result register
  ueq_dpath #(
    .NUM_EVENTS (NUM_EVENTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
